/* rtl/ngtt_pkg.sv */
// ngtt_pkg: shared types, character codes and defaults of the gga time trigger
// used by ngtt_ctrl, ngtt_dpath and nmea_gga_time_trigger; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ngtt_pkg;

	localparam int LINE_LEN_DEF = 128;

	localparam int CHAR_W  = 8;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 1;
	localparam int VAL_W   = 7;
	localparam int OUT_W   = 32;
	localparam int DIV_STEPS = VAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MINUTE  = 1'd1;

	localparam logic [CFG_W-1:0] MINUTE_INTERVAL_RST = 6'd10;
	localparam logic [CFG_W-1:0] TRIGGER_MINUTE_RST  = 6'd0;

	localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_G       = 8'h47;
	localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
	localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

	localparam logic [3:0] NOT_DIGIT = 4'd15;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic result_hit;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/ngtt_ctrl.sv */
// ngtt_ctrl: sequencer of the gga time trigger (accept, minute modulo, output hand-off)
// depends on ngtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ngtt_ctrl
	import ngtt_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  wire  m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && sts.result_hit) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_OUT:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	a_hit_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && s_tvalid && sts.result_hit) |=> state_q == ST_DIV)
		else $error("result hit did not start the minute modulo");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> state_q == ST_DIV)
		else $error("minute modulo left early");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT && m_valid_q))
		else $error("result dropped while output was busy");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

/* rtl/ngtt_dpath.sv */
// ngtt_dpath: sentence parser state, digit groups, bit-serial minute modulo, output register
// depends on ngtt_pkg; driven by ngtt_ctrl
`timescale 1ns / 1ps
`default_nettype none

module ngtt_dpath
	import ngtt_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  wire [CHAR_W-1:0]     rx_char,
	input  wire                  cfg_valid,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]      cfg_data,
	output logic [OUT_W-1:0]     out_data
);

	localparam int POS_W = $clog2(LINE_LEN);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_LEN - 1);

	// parser state
	logic [POS_W-1:0] pos_q;
	logic             g_ok_q, a_ok_q;
	logic [1:0]       comma_q;
	logic [3:0]       fdc_q;
	logic [7:0][3:0]  td_q;

	logic [CFG_W-1:0] interval_q, trigger_q;

	// work registers
	logic [VAL_W-1:0]     hh_q, mm_q, ss_q, frac_q;
	logic [VAL_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	// next-state values of the parser
	logic             dollar, newline;
	logic [POS_W-1:0] pos_e, pos_n;
	logic             g_e, a_e, g_n, a_n;
	logic [1:0]       comma_e, comma_n;
	logic [3:0]       fdc_e, fdc_n;
	logic [7:0][3:0]  td_n;
	logic [3:0]       code;
	logic             hit;

	function automatic logic [VAL_W-1:0] group_val(input logic [3:0] a, input logic [3:0] b,
			input logic [3:0] fdc, input logic [3:0] pa);
		logic [VAL_W-1:0] av;
		av = VAL_W'(a);
		if (fdc <= pa) group_val = '0;
		else if (a > 4'd9) group_val = '0;
		else if (fdc <= pa + 4'd1) group_val = av;
		else if (b > 4'd9) group_val = av;
		else group_val = (av << 3) + (av << 1) + VAL_W'(b);
	endfunction

	always_comb begin
		dollar  = (rx_char == CH_DOLLAR);
		newline = (rx_char == CH_NEWLINE);
		code    = (rx_char >= CH_ZERO && rx_char <= CH_NINE) ? rx_char[3:0] : NOT_DIGIT;

		pos_e   = dollar ? '0 : pos_q;
		g_e     = dollar ? 1'b0 : g_ok_q;
		a_e     = dollar ? 1'b0 : a_ok_q;
		comma_e = dollar ? 2'd0 : comma_q;
		fdc_e   = dollar ? 4'd0 : fdc_q;

		g_n   = (pos_e == POS_W'(4)) ? (rx_char == CH_G) : g_e;
		a_n   = (pos_e == POS_W'(5)) ? (rx_char == CH_A) : a_e;
		pos_n = (pos_e < POS_MAX) ? pos_e + POS_W'(1) : pos_e;

		hit = newline && g_n && a_n && (comma_e != 2'd0) && (fdc_e != 4'd0);

		comma_n = comma_e;
		fdc_n   = fdc_e;
		td_n    = td_q;
		if (newline) begin
			// only the position and the G and A marks change unless a result goes out
		end else if (rx_char == CH_COMMA) begin
			if (comma_e != 2'd2) comma_n = comma_e + 2'd1;
		end else if (comma_e == 2'd1) begin
			if (fdc_e < 4'd6) td_n[fdc_e[2:0]] = code;
			else if (fdc_e == 4'd6) td_n[6] = (rx_char == CH_DOT) ? 4'd0 : NOT_DIGIT;
			else if (fdc_e == 4'd7) begin
				if (td_q[6] != NOT_DIGIT) td_n[6] = code;
			end else if (fdc_e == 4'd8) td_n[7] = code;
			if (fdc_e != 4'd15) fdc_n = fdc_e + 4'd1;
		end
	end

	// fraction: only when position six was a dot
	logic [VAL_W-1:0] frac_v, f6;
	always_comb begin
		f6     = VAL_W'(td_q[6]);
		frac_v = '0;
		if (fdc_q >= 4'd8 && td_q[6] <= 4'd9) begin
			frac_v = (f6 << 3) + (f6 << 1);
			if (fdc_q >= 4'd9 && td_q[7] <= 4'd9) frac_v = frac_v + VAL_W'(td_q[7]);
		end
	end

	assign sts.result_hit = hit;
	assign sts.div_last   = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			g_ok_q     <= 1'b0;
			a_ok_q     <= 1'b0;
			comma_q    <= 2'd0;
			fdc_q      <= 4'd0;
			td_q       <= '0;
			interval_q <= MINUTE_INTERVAL_RST;
			trigger_q  <= TRIGGER_MINUTE_RST;
			cnt_q      <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MINUTE_INTERVAL: interval_q <= cfg_data;
					REG_TRIGGER_MINUTE:  trigger_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				pos_q <= pos_n;
				if (hit) begin
					g_ok_q  <= 1'b0;
					a_ok_q  <= 1'b0;
					comma_q <= 2'd0;
					fdc_q   <= 4'd0;
					td_q    <= '0;
					cnt_q   <= DIV_CNT_W'(DIV_STEPS - 1);
				end else begin
					g_ok_q  <= g_n;
					a_ok_q  <= a_n;
					comma_q <= comma_n;
					fdc_q   <= fdc_n;
					td_q    <= td_n;
				end
			end else if (cmd.div_step && cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	// time groups and restoring modulo, one minute bit per step from the top
	logic [VAL_W-1:0] rem_sh;
	assign rem_sh = {rem_q[VAL_W-2:0], mm_q[cnt_q]};

	always_ff @(posedge clk) begin
		if (cmd.accept && hit) begin
			hh_q   <= group_val(td_q[0], td_q[1], fdc_q, 4'd0);
			mm_q   <= group_val(td_q[2], td_q[3], fdc_q, 4'd2);
			ss_q   <= group_val(td_q[4], td_q[5], fdc_q, 4'd4);
			frac_q <= frac_v;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= (rem_sh >= VAL_W'(interval_q)) ? rem_sh - VAL_W'(interval_q) : rem_sh;
		end
	end

	// output register, fields from the lowest bit up
	logic pulse;
	assign pulse = (ss_q == '0) && (interval_q != '0) && (rem_q == VAL_W'(trigger_q));

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data <= {{(OUT_W - 4 * VAL_W - 1){1'b0}}, pulse, frac_q, ss_q, mm_q, hh_q};
		end
	end

endmodule

`default_nettype wire

/* rtl/nmea_gga_time_trigger.sv */
// nmea_gga_time_trigger: nmea 0183 gga time parser with minute-based start pulse
// depends on ngtt_pkg, ngtt_ctrl, ngtt_dpath
`timescale 1ns / 1ps
`default_nettype none

// a character that ends no result is taken while idle and leaves the block ready
// a newline that closes a gga sentence with a time field runs a 7-step bit-serial
// minute modulo (one step per cycle); the result is registered once the output is free
// throughput: one character per cycle, but none while a result is in the modulo or waits
// reset: arst_n clears parser state, sequencer and output valid; registers take
// minute_interval 10 and trigger_minute 0
module nmea_gga_time_trigger
	import ngtt_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// input characters
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire [CHAR_W-1:0]     s_tdata,   // rx_char[7:0]
	// time results
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // hours[6:0], minutes[13:7], seconds[20:14],
	                                        // hundredths[27:21], start_pulse[28], zero[31:29]
	// register writes
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]      cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer: idle/accept, modulo steps, output hand-off
	ngtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// parser, digit groups, modulo unit, output register
	ngtt_dpath #(
		.LINE_LEN (LINE_LEN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rx_char   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

/* tb/nmea_gga_time_trigger_chk.sv */
`timescale 1ns / 1ps
// nmea_gga_time_trigger_chk: follows the character, result and register channels,
// predicts every gga time result and compares it field by field
// depends on ngtt_pkg for widths, character codes and register indexes

module nmea_gga_time_trigger_chk
	import ngtt_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  s_tready,
	input  wire [CHAR_W-1:0]     s_tdata,
	input  wire                  m_tvalid,
	input  wire                  m_tready,
	input  wire [OUT_W-1:0]      m_tdata,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]      cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   times_seen,
	output int                   pulses_seen
);

	typedef struct packed {
		logic             pulse;
		logic [VAL_W-1:0] hund;
		logic [VAL_W-1:0] secs;
		logic [VAL_W-1:0] mins;
		logic [VAL_W-1:0] hrs;
	} gga_time_t;

	gga_time_t        due_times[$];
	logic [CFG_W-1:0] interval_r;
	logic [CFG_W-1:0] trigger_r;

	// parser state
	logic [7:0]       line_pos;
	logic             mark_g;
	logic             mark_a;
	logic [1:0]       comma_n;
	logic [3:0]       field_n;
	logic [3:0]       codes [8];

	bit               got_time;
	gga_time_t        new_time;

	initial begin
		mismatches  = 0;
		times_seen  = 0;
		pulses_seen = 0;
		pending     = 0;
	end

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 25) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// two-digit group at field positions pa and pa+1
	function automatic int unsigned pair_value(input int unsigned pa);
		int unsigned hi;
		int unsigned lo;
		if (field_n <= pa) return 0;
		hi = codes[pa];
		if (hi > 9) return 0;
		if (field_n <= pa + 1) return hi;
		lo = codes[pa + 1];
		if (lo > 9) return hi;
		return hi * 10 + lo;
	endfunction

	task automatic store_char(input logic [7:0] c);
		logic [3:0] code;
		code = (c >= CH_ZERO && c <= CH_NINE) ? 4'(c - CH_ZERO) : NOT_DIGIT;
		if (field_n < 6) begin
			codes[field_n] = code;
		end else if (field_n == 6) begin
			codes[6] = (c == CH_DOT) ? 4'd0 : NOT_DIGIT;
		end else if (field_n == 7) begin
			if (codes[6] != NOT_DIGIT) codes[6] = code;
		end else if (field_n == 8) begin
			codes[7] = code;
		end
		if (field_n != 4'd15) field_n = field_n + 4'd1;
	endtask

	task automatic parse_char(input logic [7:0] c, output bit hit, output gga_time_t t);
		int unsigned hh;
		int unsigned mm;
		int unsigned ss;
		int unsigned frac;
		hit = 1'b0;
		t   = '0;
		if (c == CH_DOLLAR) begin
			line_pos = '0;
			mark_g   = 1'b0;
			mark_a   = 1'b0;
			comma_n  = '0;
			field_n  = '0;
		end
		if (line_pos == 8'd4) mark_g = (c == CH_G);
		if (line_pos == 8'd5) mark_a = (c == CH_A);
		if (line_pos < LINE_LEN - 1) line_pos = line_pos + 8'd1;

		if (c == CH_NEWLINE) begin
			if (mark_g && mark_a && comma_n != 0 && field_n != 0) begin
				hh   = pair_value(0);
				mm   = pair_value(2);
				ss   = pair_value(4);
				frac = 0;
				if (field_n >= 8 && codes[6] <= 9) begin
					frac = codes[6] * 10;
					if (field_n >= 9 && codes[7] <= 9) frac += codes[7];
				end
				t.hrs   = hh[VAL_W-1:0];
				t.mins  = mm[VAL_W-1:0];
				t.secs  = ss[VAL_W-1:0];
				t.hund  = frac[VAL_W-1:0];
				t.pulse = (ss == 0 && interval_r != 0 && (mm % interval_r) == trigger_r);
				hit     = 1'b1;
				mark_g  = 1'b0;
				mark_a  = 1'b0;
				comma_n = '0;
				field_n = '0;
				foreach (codes[i]) codes[i] = '0;
			end
		end else if (c == CH_COMMA) begin
			if (comma_n < 2) comma_n = comma_n + 2'd1;
		end else if (comma_n == 2'd1) begin
			store_char(c);
		end
	endtask

	task automatic check_time();
		gga_time_t want;
		times_seen++;
		if (m_tdata[28]) pulses_seen++;
		if (due_times.size() == 0) begin
			report($sformatf("result %h arrived with none expected", m_tdata));
			return;
		end
		want = due_times.pop_front();
		if (m_tdata[6:0] != want.hrs)
			report($sformatf("hours %0d, expected %0d", m_tdata[6:0], want.hrs));
		if (m_tdata[13:7] != want.mins)
			report($sformatf("minutes %0d, expected %0d", m_tdata[13:7], want.mins));
		if (m_tdata[20:14] != want.secs)
			report($sformatf("seconds %0d, expected %0d", m_tdata[20:14], want.secs));
		if (m_tdata[27:21] != want.hund)
			report($sformatf("hundredths %0d, expected %0d", m_tdata[27:21], want.hund));
		if (m_tdata[28] != want.pulse)
			report($sformatf("start_pulse %0b, expected %0b", m_tdata[28], want.pulse));
		if (m_tdata[31:29] != 3'd0)
			report($sformatf("padding bits %b not zero", m_tdata[31:29]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_r = MINUTE_INTERVAL_RST;
			trigger_r  = TRIGGER_MINUTE_RST;
			line_pos   = '0;
			mark_g     = 1'b0;
			mark_a     = 1'b0;
			comma_n    = '0;
			field_n    = '0;
			foreach (codes[i]) codes[i] = '0;
			due_times.delete();
			pending <= 0;
		end else begin
			// results first: the oldest expectation always predates this edge
			if (m_tvalid && m_tready) check_time();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MINUTE_INTERVAL: interval_r = cfg_data;
					REG_TRIGGER_MINUTE:  trigger_r  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata, got_time, new_time);
				if (got_time) due_times.push_back(new_time);
			end
			pending <= due_times.size();
		end
	end

endmodule

/* tb/nmea_gga_time_trigger_tb.sv */
`timescale 1ns / 1ps
// nmea_gga_time_trigger_tb: drives nmea sentences and register writes into the gga
// time trigger; checking is done by nmea_gga_time_trigger_chk beside the block
// depends on ngtt_pkg, nmea_gga_time_trigger and nmea_gga_time_trigger_chk

module nmea_gga_time_trigger_tb;
	import ngtt_pkg::*;

	localparam int SETTLE       = 16;
	localparam int LIMIT        = 1000000;   // cycle budget for the whole run
	localparam int RANDOM_CHARS = 720;
	localparam int PHASES       = 6;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic [CHAR_W-1:0]    s_tdata   = '0;
	logic                 m_tready  = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	wire                  s_tready;
	wire                  m_tvalid;
	wire  [OUT_W-1:0]     m_tdata;
	wire                  cfg_ready;

	// checker outputs
	int mismatch_n;
	int times_due;
	int times_n;
	int pulses_n;

	int   sent_n     = 0;
	int   settings_n = 1;       // the reset values count as the first setting
	int   cycle_n    = 0;
	int   stall_left = 0;
	int   rx_roll;
	bit   tx_calm    = 1'b0;    // sender never idles
	bit   rx_calm    = 1'b0;    // receiver never stalls
	logic [CFG_W-1:0] cur_iv = MINUTE_INTERVAL_RST;
	logic [CFG_W-1:0] cur_tm = TRIGGER_MINUTE_RST;
	logic [7:0]       line_q[$];

	always #5 clk = ~clk;

	nmea_gga_time_trigger u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nmea_gga_time_trigger_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatch_n),
		.pending     (times_due),
		.times_seen  (times_n),
		.pulses_seen (pulses_n)
	);

	// run-away guard
	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_n, times_due);
			$display("** nmea_gga_time_trigger: FAILED **");
			$finish;
		end
	end

	// result side: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		if (rx_calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 70) begin
				m_tready <= 1'b1;
			end else begin
				stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				m_tready <= 1'b0;
			end
		end
	end

	task automatic push_ch(input logic [7:0] c);
		line_q.push_back(c);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	// two ascii digits of a value 0..99
	task automatic push_pair(input int v);
		push_ch(8'(CH_ZERO + v / 10));
		push_ch(8'(CH_ZERO + v % 10));
	endtask

	// one character transfer, with a random idle gap in front of it
	task automatic send_char(input logic [7:0] c);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (tx_calm || roll < 60)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		sent_n++;
	endtask

	task automatic send_queue();
		while (line_q.size() != 0) send_char(line_q.pop_front());
	endtask

	task automatic send_text(input string s);
		push_text(s);
		send_queue();
	endtask

	// hold the sender until every predicted result has been taken
	task automatic drain_times();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (times_due != 0) @(posedge clk);
	endtask

	// a newline that makes no result never leaves the idle state, yet wait a little more
	task automatic settle();
		drain_times();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input int iv, input int tm);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_MINUTE_INTERVAL;
		cfg_data  <= CFG_W'(iv);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_TRIGGER_MINUTE;
		cfg_data  <= CFG_W'(tm);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_iv = CFG_W'(iv);
		cur_tm = CFG_W'(tm);
		settings_n++;
	endtask

	initial begin
		int ph;
		int goal;
		int kind;
		int n;
		int k;
		int mm;
		int fl;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, registers at reset values (interval 10, trigger 0)
		send_text("$GPGGA,123519.25,4807.038,N,01131.000,E\n");  // plain sentence
		send_text("$GPGGA,002000.00,\n");        // minute 20 on the interval: pulse
		send_text("$GNGGA,995999.99,\n");        // hours, seconds and hundredths at 99, minutes at 59
		send_text("$GPGGA,,\n");                 // empty time field
		send_text("$GPGGA,,123\n");              // time only after the second comma
		send_text("$GPGGA\n");                   // no comma at all
		send_text("$GPRMC,123519,A\n");          // other sentence type
		send_text("$GPGGA,1234\n");              // seconds missing
		send_text("$GPGGA,1\n");                 // lone hour digit
		send_text("$GPGGA,12a4b6\n");            // letters inside groups
		send_text("$GPGGA,x1\n");                // leading non-digit
		send_text("$GPGGA,120000.5\n");          // single fraction digit
		send_text("$GPGGA,120000x55\n");         // fraction without a dot
		send_text("$GPGGA,103000.123456789012\n"); // digits past the fraction
		send_text("$GPGGA\n,223344\n");          // newline without result keeps the line
		send_text("$GPGGA,1234$GP\n");           // dollar inside a line
		send_text("12,34\n");                    // no dollar after a result
		// over-long line: position saturates, parsing goes on
		push_text("$GPGGA,101010.10,");
		repeat (200) push_text("x");
		push_ch(CH_NEWLINE);
		send_queue();
		send_text("GPGGA,1200\n");               // position stuck at the end of the line
		push_text("$GPGGA,");                    // all-zero and all-one characters
		push_ch(8'h00);
		push_ch(8'hFF);
		push_text("9\n");
		send_queue();

		// zero interval never fires, then the top register values
		set_regs(0, 0);
		send_text("$GPGGA,000000\n");
		set_regs(63, 63);
		send_text("$GPGGA,996300.99\n");

		// random part: mostly gga sentences with random time fields
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       set_regs(1, 0);
				1:       set_regs(59, 59);
				2:       set_regs(59, 0);
				3:       set_regs(0, 0);
				4:       set_regs($urandom_range(2, 15), $urandom_range(0, 1));
				default: set_regs($urandom_range(1, 59), $urandom_range(0, 59));
			endcase
			tx_calm = (ph == 2) || ($urandom_range(0, 4) == 0);
			rx_calm = (ph == 4) || ($urandom_range(0, 4) == 0);
			goal = sent_n + RANDOM_CHARS / PHASES;
			while (sent_n < goal) begin
				kind = $urandom_range(0, 99);
				if (kind < 72) begin
					// gga sentence, sometimes with a bad sentence type mark
					push_ch(CH_DOLLAR);
					push_text($urandom_range(0, 1) ? "GP" : "GN");
					push_text("GGA");
					if ($urandom_range(0, 9) == 0)
						line_q[$urandom_range(4, 5)] = 8'($urandom_range(8'h41, 8'h5A));
					push_ch(CH_COMMA);
					// steer the minutes onto the trigger half of the time
					if (cur_iv != 0 && $urandom_range(0, 1)) begin
						k  = cur_tm + cur_iv * $urandom_range(0, 3);
						mm = (k <= 99) ? k : $urandom_range(0, 99);
					end else begin
						mm = $urandom_range(0, 99);
					end
					push_pair(($urandom_range(0, 3) == 0) ? $urandom_range(24, 99)
					                                       : $urandom_range(0, 23));
					push_pair(mm);
					push_pair($urandom_range(0, 1) ? 0 : $urandom_range(0, 99));
					fl = $urandom_range(0, 9);
					if (fl < 6) begin
						push_ch(CH_DOT);
						push_pair($urandom_range(0, 99));
					end else if (fl == 6) begin
						push_ch(CH_DOT);
						push_ch(8'(CH_ZERO + $urandom_range(0, 9)));
					end else if (fl == 7) begin
						push_ch(8'($urandom_range(33, 126)));
						push_pair($urandom_range(0, 99));
					end
					// cut the field short
					if ($urandom_range(0, 5) == 0) begin
						n = $urandom_range(7, line_q.size());
						while (line_q.size() > n) void'(line_q.pop_back());
					end
					// damage one character of the field
					if ($urandom_range(0, 7) == 0 && line_q.size() > 7)
						line_q[$urandom_range(7, line_q.size() - 1)] = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 2) == 0) push_text(",4807.0,N");
					push_ch(CH_NEWLINE);
				end else if (kind < 86) begin
					// other sentences and short lines
					case ($urandom_range(0, 2))
						0:       push_text("$GPRMC,");
						1:       push_text("$GPGSA,");
						default: push_text("$GP");
					endcase
					if ($urandom_range(0, 1)) push_pair($urandom_range(0, 99));
					push_ch(CH_NEWLINE);
				end else begin
					// noise over the whole byte range
					n = $urandom_range(1, 20);
					repeat (n) push_ch(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1)) push_ch(CH_NEWLINE);
				end
				send_queue();
				if ($urandom_range(0, 29) == 0) drain_times();
			end
		end

		settle();
		$display("covered %0d characters, %0d time results of which %0d with start pulse,",
		         sent_n, times_n, pulses_n);
		$display("over %0d register settings with random idling on both channels", settings_n);
		if (mismatch_n == 0) begin
			$display("** nmea_gga_time_trigger: PASSED **");
		end else begin
			$display("** nmea_gga_time_trigger: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/ngtt_pkg.sv
rtl/ngtt_ctrl.sv
rtl/ngtt_dpath.sv
rtl/nmea_gga_time_trigger.sv
tb/nmea_gga_time_trigger_chk.sv
tb/nmea_gga_time_trigger_tb.sv
